// ===== src/rcb_pkg.sv =====
// Shared types, constants and the cadence ROM for the ring cadence bridge driver.
// Used by every module under src; depends on nothing.
package rcb_pkg;

  localparam int PATTERN_TOTAL = 2;
  localparam int DURATION_BITS = 16;
  localparam int ROM_DEPTH     = 8;
  localparam int INDEX_BITS    = $clog2(ROM_DEPTH);
  localparam int ROM_BITS      = 16;
  localparam int CMP_BITS      = 32;
  localparam int TOGGLE_BITS   = 10;

  localparam logic [TOGGLE_BITS-1:0] TOGGLE_RESET = TOGGLE_BITS'(25);

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] pattern_num;
  } rcb_req_t;

  typedef struct packed {
    logic                  drive_a;
    logic                  drive_b;
    logic                  ringing_active;
    logic [INDEX_BITS-1:0] segment_number;
    logic                  in_on_segment;
  } rcb_res_t;

  // Segment lengths in milliseconds; a zero entry wraps the pattern.
  function automatic logic [ROM_BITS-1:0] cadence_rom(input logic pattern,
                                                      input logic [INDEX_BITS-1:0] idx);
    logic [ROM_BITS-1:0] dur;
    dur = '0;
    if (pattern == 1'b0) begin
      unique case (idx)
        3'd0:    dur = ROM_BITS'(2000);
        3'd1:    dur = ROM_BITS'(4000);
        default: dur = '0;
      endcase
    end else begin
      unique case (idx)
        3'd0:    dur = ROM_BITS'(400);
        3'd1:    dur = ROM_BITS'(200);
        3'd2:    dur = ROM_BITS'(400);
        3'd3:    dur = ROM_BITS'(200);
        3'd4:    dur = ROM_BITS'(800);
        3'd5:    dur = ROM_BITS'(4000);
        default: dur = '0;
      endcase
    end
    return dur;
  endfunction

endpackage

// ===== src/ring_cadence_bridge_driver.sv =====
// Top level of the ring cadence bridge driver: channels, config register, result register.
// Depends on rcb_pkg, rcb_in_stage and rcb_core.
//
// Usage: each request transaction on the req channel is a one millisecond tick,
// a start command with a pattern number, or a stop command. Every request
// produces exactly one result transaction on the res channel carrying the two
// H-bridge drive levels, the ringing flag, the current segment number and the on-segment flag.
// The cfg channel writes the toggle interval (ticks between polarity swaps);
// it is always ready and should only be written while no request is in flight.
// Flow: an accepted request sits in the input register and is processed once
// the result register can load; that load offers its result transaction on
// the res channel. Throughput is one request per cycle while the receiver
// takes each result, set by the combinational state update in the cadence core.
// Reset (synchronous, active high) empties both registers, stops ringing,
// drives both bridge inputs low and restores the toggle interval to 25.
// When the receiver stalls, the result register holds its transaction, the
// input register can still take one more request, and then req_ready drops
// until the result is taken.
module ring_cadence_bridge_driver (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  rcb_pkg::rcb_req_t               req,
  output logic                            res_valid,
  input  logic                            res_ready,
  output rcb_pkg::rcb_res_t               res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcb_pkg::TOGGLE_BITS-1:0] cfg_data
);
  import rcb_pkg::*;

  logic                   advance;
  logic                   held_valid;
  rcb_req_t               held;
  rcb_res_t               core_result;
  logic [TOGGLE_BITS-1:0] toggle_interval;
  logic                   step;

  // The configuration register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      toggle_interval <= TOGGLE_RESET;
    end else if (cfg_valid) begin
      toggle_interval <= cfg_data;
    end
  end

  // The result register can load whenever it is empty or being drained.
  assign advance = !res_valid || res_ready;
  assign step    = held_valid && advance;

  rcb_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  rcb_core u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .item            (held),
    .toggle_interval (toggle_interval),
    .result          (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= core_result;
    end
  end

endmodule

// ===== src/rcb_in_stage.sv =====
// Input register of the ring cadence bridge driver: holds one request transaction.
// Depends on rcb_pkg for the request type.
module rcb_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  rcb_pkg::rcb_req_t req,
  input  logic             advance,
  output logic             held_valid,
  output rcb_pkg::rcb_req_t held
);
  import rcb_pkg::*;

  // The register frees up whenever its content moves on in this cycle.
  assign req_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req_ready) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      held <= req;
    end
  end

endmodule

// ===== src/rcb_core.sv =====
// Cadence state and its single-cycle update for one request.
// Depends on rcb_pkg for types, request codes and the cadence ROM.
module rcb_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  rcb_pkg::rcb_req_t              item,
  input  logic [rcb_pkg::TOGGLE_BITS-1:0] toggle_interval,
  output rcb_pkg::rcb_res_t              result
);
  import rcb_pkg::*;

  localparam logic [DURATION_BITS-1:0] COUNT_MAX = '1;

  logic                     active_flag, active_flag_next;
  logic                     polarity, polarity_next;
  logic                     pattern_select, pattern_select_next;
  logic [INDEX_BITS-1:0]    segment_index, segment_index_next;
  logic [DURATION_BITS-1:0] segment_elapsed, segment_elapsed_next;
  logic [DURATION_BITS-1:0] since_toggle, since_toggle_next;
  logic                     pin_a, pin_a_next;
  logic                     pin_b, pin_b_next;

  logic [ROM_BITS-1:0]      dur;
  logic [DURATION_BITS-1:0] el_inc, st_inc;

  always_comb begin
    active_flag_next     = active_flag;
    polarity_next        = polarity;
    pattern_select_next  = pattern_select;
    segment_index_next   = segment_index;
    segment_elapsed_next = segment_elapsed;
    since_toggle_next    = since_toggle;
    pin_a_next           = pin_a;
    pin_b_next           = pin_b;
    el_inc = (segment_elapsed == COUNT_MAX) ? COUNT_MAX : segment_elapsed + 1'b1;
    st_inc = (since_toggle == COUNT_MAX) ? COUNT_MAX : since_toggle + 1'b1;
    dur    = cadence_rom(pattern_select, segment_index);

    unique case (item.req_type)
      REQ_TICK: begin
        if (active_flag) begin
          segment_elapsed_next = el_inc;
          since_toggle_next    = st_inc;
          // A zero entry marks the end of the pattern: restart at its first segment.
          if (dur == '0) begin
            segment_index_next   = '0;
            segment_elapsed_next = '0;
            dur                  = cadence_rom(pattern_select, '0);
          end
          if (CMP_BITS'(segment_elapsed_next) >= CMP_BITS'(dur)) begin
            segment_index_next   = segment_index_next + 1'b1;
            segment_elapsed_next = '0;
            polarity_next        = 1'b0;
            pin_a_next           = 1'b0;
            pin_b_next           = 1'b0;
          end else if (segment_index_next[0]) begin
            polarity_next = 1'b0;
            pin_a_next    = 1'b0;
            pin_b_next    = 1'b0;
          end else if (CMP_BITS'(st_inc) >= CMP_BITS'(toggle_interval)) begin
            polarity_next     = !polarity;
            pin_a_next        = !polarity;
            pin_b_next        = polarity;
            since_toggle_next = '0;
          end
        end
      end
      REQ_START: begin
        active_flag_next     = 1'b1;
        polarity_next        = 1'b0;
        pin_a_next           = 1'b0;
        pin_b_next           = 1'b0;
        pattern_select_next  = (32'(item.pattern_num) >= 32'(PATTERN_TOTAL)) ? 1'b0
                                                                            : item.pattern_num[0];
        segment_index_next   = '0;
        segment_elapsed_next = '0;
        since_toggle_next    = '0;
      end
      REQ_STOP: begin
        active_flag_next = 1'b0;
        polarity_next    = 1'b0;
        pin_a_next       = 1'b0;
        pin_b_next       = 1'b0;
      end
      default: begin
      end
    endcase

    result.drive_a        = pin_a_next;
    result.drive_b        = pin_b_next;
    result.ringing_active = active_flag_next;
    result.segment_number = segment_index_next;
    result.in_on_segment  = !segment_index_next[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag     <= 1'b0;
      polarity        <= 1'b0;
      pattern_select  <= 1'b0;
      segment_index   <= '0;
      segment_elapsed <= '0;
      since_toggle    <= '0;
      pin_a           <= 1'b0;
      pin_b           <= 1'b0;
    end else if (step) begin
      active_flag     <= active_flag_next;
      polarity        <= polarity_next;
      pattern_select  <= pattern_select_next;
      segment_index   <= segment_index_next;
      segment_elapsed <= segment_elapsed_next;
      since_toggle    <= since_toggle_next;
      pin_a           <= pin_a_next;
      pin_b           <= pin_b_next;
    end
  end

endmodule
